### hdl/trapezoid_peak_utility_assert.svh
// assertion macros for the trapezoid peak utility block
`ifndef TRAPEZOID_PEAK_UTILITY_ASSERT_SVH
`define TRAPEZOID_PEAK_UTILITY_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define TPU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trapezoid_peak_utility: assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define TPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trapezoid_peak_utility: assertion failed");
`else
`define TPU_ASSERT_IMP(label, ante, cons)
`define TPU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/tpu_pkg.sv
package tpu_pkg;

    localparam int TPU_FRACTION_BITS = 8;
    localparam int TPU_MAX_POINTS    = 1024;

    localparam int TPU_IDX_W     = 10;
    localparam int TPU_CFG_W     = 11;
    localparam int TPU_CFG_IDX_W = 3;
    localparam int TPU_DROP_W    = 7;
    localparam int TPU_HI_W      = 11;
    localparam int TPU_DEN_W     = 10;
    localparam int TPU_NUM_W     = 17;
    localparam int TPU_FULL_W    = 7;
    localparam int TPU_UTIL_W    = 15;
    localparam int TPU_SEG_W     = 3;

    localparam logic [TPU_DROP_W-1:0] TPU_FULL_UTIL = 7'd100;
    localparam logic [TPU_HI_W-1:0]   TPU_N_MIN     = 11'd2;
    localparam logic [TPU_HI_W-1:0]   TPU_N_RESET   = 11'd1024;
    localparam logic [TPU_HI_W-1:0]   TPU_N_CAP     =
        (TPU_MAX_POINTS > 2047) ? 11'd2047 : TPU_HI_W'(TPU_MAX_POINTS);

    // configuration register indexes
    localparam logic [TPU_CFG_IDX_W-1:0] REG_SUMMIT_POINT       = 3'd0;
    localparam logic [TPU_CFG_IDX_W-1:0] REG_PLATEAU_HALF_WIDTH = 3'd1;
    localparam logic [TPU_CFG_IDX_W-1:0] REG_BASE_RAMP_WIDTH    = 3'd2;
    localparam logic [TPU_CFG_IDX_W-1:0] REG_SUMMIT_DROP        = 3'd3;
    localparam logic [TPU_CFG_IDX_W-1:0] REG_POINTS_IN_USE      = 3'd4;

    // segment codes
    localparam logic [TPU_SEG_W-1:0] SEG_LOW_ZERO  = 3'd0;
    localparam logic [TPU_SEG_W-1:0] SEG_RAMP_UP   = 3'd1;
    localparam logic [TPU_SEG_W-1:0] SEG_RISE      = 3'd2;
    localparam logic [TPU_SEG_W-1:0] SEG_SUMMIT    = 3'd3;
    localparam logic [TPU_SEG_W-1:0] SEG_FALL      = 3'd4;
    localparam logic [TPU_SEG_W-1:0] SEG_RAMP_DOWN = 3'd5;
    localparam logic [TPU_SEG_W-1:0] SEG_HIGH_ZERO = 3'd6;

    typedef struct packed {
        logic [TPU_SEG_W-1:0] seg;
        logic                 shape_valid;
    } tpu_tag_t;

endpackage

### hdl/tpu_div_pipe.sv
module tpu_div_pipe
    import tpu_pkg::*;
#(
    parameter int FRACTION_BITS = TPU_FRACTION_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [TPU_NUM_W-1:0]              in_num,
    input  logic [TPU_DEN_W-1:0]              in_den,
    input  tpu_tag_t                          in_tag,
    output logic                              out_valid,
    output logic [TPU_FULL_W+FRACTION_BITS-1:0] out_quot,
    output tpu_tag_t                          out_tag
);

    localparam int QW = TPU_FULL_W + FRACTION_BITS;

    logic                 valid_reg [QW];
    logic [TPU_DEN_W-1:0] rem_reg   [QW];
    logic [QW-1:0]        lo_reg    [QW];
    logic [QW-1:0]        q_reg     [QW];
    logic [TPU_DEN_W-1:0] den_reg   [QW];
    tpu_tag_t             tag_reg   [QW];

    // one quotient bit per stage, restoring form; quotient fits QW bits
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic                 v_in;
        logic [TPU_DEN_W-1:0] rem_in;
        logic [QW-1:0]        lo_in;
        logic [QW-1:0]        q_in;
        logic [TPU_DEN_W-1:0] den_in;
        tpu_tag_t             tag_in;
        logic [TPU_DEN_W:0]   trial;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = in_num[TPU_NUM_W-1:TPU_FULL_W];
            assign lo_in  = QW'(in_num[TPU_FULL_W-1:0]) << FRACTION_BITS;
            assign q_in   = '0;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end
        else
        begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign trial = {rem_in, lo_in[QW-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? TPU_DEN_W'(trial - {1'b0, den_in}) : trial[TPU_DEN_W-1:0];
            lo_reg[k]  <= lo_in << 1;
            q_reg[k]   <= {q_in[QW-2:0], ge};
            den_reg[k] <= den_in;
            tag_reg[k] <= tag_in;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quot  = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

### hdl/trapezoid_peak_utility.sv
// Evaluates the trapezoidal peak utility at one point index per clock. An item is taken
// whenever start is high (busy is always low), and its result appears on utility, segment
// and shape_valid with done high for one cycle, in start order; the receiver cannot stall,
// so results must be taken when done is high. Each item passes through five stages of shape
// decode, classification and multiply and then the pipelined restoring divider, one
// quotient bit per stage. Register writes through cfg_we/cfg_index/cfg_data apply to items
// started on or after the write edge and must not be made while items are still in flight.
`include "trapezoid_peak_utility_assert.svh"

module trapezoid_peak_utility
    import tpu_pkg::*;
#(
    parameter int FRACTION_BITS = TPU_FRACTION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [TPU_IDX_W-1:0]     point_index,
    output logic                     done,
    output logic [TPU_UTIL_W-1:0]    utility,
    output logic [TPU_SEG_W-1:0]     segment,
    output logic                     shape_valid,
    input  logic                     cfg_we,
    input  logic [TPU_CFG_IDX_W-1:0] cfg_index,
    input  logic [TPU_CFG_W-1:0]     cfg_data
);

    localparam int QW      = TPU_FULL_W + FRACTION_BITS;
    localparam int LATENCY = 5 + QW;
    localparam logic [TPU_UTIL_W-1:0] UTIL_SUMMIT =
        TPU_UTIL_W'(int'(TPU_FULL_UTIL) << FRACTION_BITS);

    typedef struct packed {
        logic [TPU_HI_W-1:0]   hi;
        logic [TPU_IDX_W-1:0]  platlow;
        logic [TPU_HI_W-1:0]   plathigh;
        logic [TPU_IDX_W-1:0]  sum;
        logic [TPU_IDX_W-1:0]  swlo;
        logic                  svalid;
        logic [TPU_DROP_W-1:0] drop;
        logic [TPU_DROP_W-1:0] plat;
        logic [TPU_IDX_W-1:0]  s;
        logic [TPU_IDX_W-1:0]  w;
        logic [TPU_IDX_W-1:0]  b;
    } shape_a_t;

    typedef struct packed {
        logic [TPU_HI_W-1:0]   hi;
        logic [TPU_IDX_W-1:0]  baselow;
        logic [TPU_IDX_W-1:0]  platlow;
        logic [TPU_HI_W-1:0]   plathigh;
        logic [TPU_HI_W-1:0]   basehigh;
        logic [TPU_IDX_W-1:0]  s;
        logic [TPU_IDX_W-1:0]  sum;
        logic [TPU_IDX_W-1:0]  swlo;
        logic [TPU_IDX_W-1:0]  c1;
        logic [TPU_IDX_W-1:0]  e5;
        logic [TPU_NUM_W-1:0]  platw;
        logic [TPU_DROP_W-1:0] plat;
        logic [TPU_DROP_W-1:0] drop;
        logic [TPU_IDX_W-1:0]  w;
        logic [TPU_IDX_W-1:0]  b;
        logic                  svalid;
    } shape_b_t;

    typedef struct packed {
        tpu_tag_t              tag;
        logic [TPU_DROP_W-1:0] coef;
        logic [TPU_IDX_W-1:0]  m;
        logic                  use_base;
        logic [TPU_NUM_W-1:0]  platw;
        logic [TPU_DEN_W-1:0]  den;
    } cls_t;

    logic [TPU_IDX_W-1:0]  summit_reg;
    logic [TPU_IDX_W-1:0]  phw_reg;
    logic [TPU_IDX_W-1:0]  brw_reg;
    logic [TPU_DROP_W-1:0] drop_reg;
    logic [TPU_HI_W-1:0]   pts_reg;

    shape_a_t a_next, a_reg;
    shape_b_t b_next, b_reg;
    cls_t     cls_next, cls_reg;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [TPU_IDX_W-1:0] x1_reg, x2_reg, x3_reg;
    logic [TPU_NUM_W-1:0] num_next, num_reg;
    logic [TPU_DEN_W-1:0] den_reg;
    tpu_tag_t             tag_reg;

    logic [TPU_HI_W-1:0]  n_lo;
    logic [TPU_HI_W-1:0]  n_eff;
    logic [TPU_HI_W-1:0]  sw_sum;
    logic [TPU_HI_W:0]    pb_sum;
    logic                 accept;

    logic                 div_valid;
    logic [QW-1:0]        div_quot;
    tpu_tag_t             div_tag;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summit_reg <= '0;
            phw_reg    <= '0;
            brw_reg    <= '0;
            drop_reg   <= '0;
            pts_reg    <= TPU_N_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUMMIT_POINT:       summit_reg <= cfg_data[TPU_IDX_W-1:0];
                REG_PLATEAU_HALF_WIDTH: phw_reg    <= cfg_data[TPU_IDX_W-1:0];
                REG_BASE_RAMP_WIDTH:    brw_reg    <= cfg_data[TPU_IDX_W-1:0];
                REG_SUMMIT_DROP:        drop_reg   <= cfg_data[TPU_DROP_W-1:0];
                REG_POINTS_IN_USE:      pts_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // shape decode, first half: domain top and plateau edges
    always_comb
    begin
        n_lo   = (pts_reg < TPU_N_MIN) ? TPU_N_MIN : pts_reg;
        n_eff  = (n_lo > TPU_N_CAP) ? TPU_N_CAP : n_lo;
        sw_sum = {1'b0, summit_reg} + {1'b0, phw_reg};

        a_next.hi       = n_eff - 11'd1;
        a_next.platlow  = (summit_reg > phw_reg) ? summit_reg - phw_reg : '0;
        a_next.plathigh = (sw_sum < a_next.hi) ? sw_sum : a_next.hi;
        a_next.sum      = sw_sum[TPU_IDX_W-1:0];
        a_next.swlo     = summit_reg - phw_reg;
        a_next.svalid   = {1'b0, summit_reg} <= a_next.hi;
        a_next.drop     = (drop_reg > TPU_FULL_UTIL) ? TPU_FULL_UTIL : drop_reg;
        a_next.plat     = TPU_FULL_UTIL - a_next.drop;
        a_next.s        = summit_reg;
        a_next.w        = phw_reg;
        a_next.b        = brw_reg;
    end

    // shape decode, second half: base edges and ramp offsets
    always_comb
    begin
        pb_sum = {1'b0, a_reg.plathigh} + {2'b0, a_reg.b};

        b_next.hi       = a_reg.hi;
        b_next.baselow  = (a_reg.platlow > a_reg.b) ? a_reg.platlow - a_reg.b : '0;
        b_next.platlow  = a_reg.platlow;
        b_next.plathigh = a_reg.plathigh;
        b_next.basehigh = (pb_sum < {1'b0, a_reg.hi}) ? pb_sum[TPU_HI_W-1:0] : a_reg.hi;
        b_next.s        = a_reg.s;
        b_next.sum      = a_reg.sum;
        b_next.swlo     = a_reg.swlo;
        b_next.c1       = a_reg.b - a_reg.platlow;
        b_next.e5       = a_reg.plathigh[TPU_IDX_W-1:0] + a_reg.b;
        b_next.platw    = TPU_NUM_W'(a_reg.plat) * TPU_NUM_W'(a_reg.w);
        b_next.plat     = a_reg.plat;
        b_next.drop     = a_reg.drop;
        b_next.w        = a_reg.w;
        b_next.b        = a_reg.b;
        b_next.svalid   = a_reg.svalid;
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    // segment select and ratio operands; offsets wrap in 10 bits but land in range
    always_comb
    begin
        cls_next.tag.seg         = SEG_LOW_ZERO;
        cls_next.tag.shape_valid = b_reg.svalid;
        cls_next.coef            = '0;
        cls_next.m               = '0;
        cls_next.use_base        = 1'b0;
        cls_next.platw           = b_reg.platw;
        cls_next.den             = TPU_DEN_W'(1);

        if (!b_reg.svalid)
        begin
            cls_next.tag.seg = SEG_LOW_ZERO;
        end
        else if ({1'b0, x3_reg} > b_reg.hi)
        begin
            cls_next.tag.seg = SEG_HIGH_ZERO;
        end
        else if (x3_reg < b_reg.baselow)
        begin
            cls_next.tag.seg = SEG_LOW_ZERO;
        end
        else if (x3_reg < b_reg.platlow)
        begin
            cls_next.tag.seg = SEG_RAMP_UP;
            cls_next.coef    = b_reg.plat;
            cls_next.m       = x3_reg + b_reg.c1;
            cls_next.den     = b_reg.b;
        end
        else if (x3_reg < b_reg.s)
        begin
            cls_next.tag.seg  = SEG_RISE;
            cls_next.coef     = b_reg.drop;
            cls_next.m        = x3_reg - b_reg.swlo;
            cls_next.use_base = 1'b1;
            cls_next.den      = b_reg.w;
        end
        else if (x3_reg == b_reg.s)
        begin
            cls_next.tag.seg = SEG_SUMMIT;
            cls_next.coef    = TPU_FULL_UTIL;
            cls_next.m       = TPU_IDX_W'(1);
        end
        else if ({1'b0, x3_reg} <= b_reg.plathigh)
        begin
            cls_next.tag.seg  = SEG_FALL;
            cls_next.coef     = b_reg.drop;
            cls_next.m        = b_reg.sum - x3_reg;
            cls_next.use_base = 1'b1;
            cls_next.den      = b_reg.w;
        end
        else if ({1'b0, x3_reg} <= b_reg.basehigh)
        begin
            cls_next.tag.seg = SEG_RAMP_DOWN;
            cls_next.coef    = b_reg.plat;
            cls_next.m       = b_reg.e5 - x3_reg;
            cls_next.den     = b_reg.b;
        end
        else
        begin
            cls_next.tag.seg = SEG_HIGH_ZERO;
        end
    end

    assign num_next = (cls_reg.use_base ? cls_reg.platw : '0)
                    + TPU_NUM_W'(cls_reg.coef) * TPU_NUM_W'(cls_reg.m);

    // item valid bits; index delayed so the shape decode has settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= point_index;
        x2_reg  <= x1_reg;
        x3_reg  <= x2_reg;
        cls_reg <= cls_next;
        num_reg <= num_next;
        den_reg <= cls_reg.den;
        tag_reg <= cls_reg.tag;
    end

    tpu_div_pipe #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_tag    (tag_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_tag   (div_tag)
    );

    assign done        = div_valid;
    assign utility     = TPU_UTIL_W'(div_quot);
    assign segment     = div_tag.seg;
    assign shape_valid = div_tag.shape_valid;

    `TPU_ASSERT_NEXT(a_fixed_latency, start && !busy, ##(LATENCY-1) done)
    `TPU_ASSERT_IMP(a_no_shape_zero, done && !shape_valid, segment == SEG_LOW_ZERO && utility == '0)
    `TPU_ASSERT_IMP(a_summit_full, done && segment == SEG_SUMMIT, utility == UTIL_SUMMIT)
    `TPU_ASSERT_IMP(a_outside_zero, done && (segment == SEG_LOW_ZERO || segment == SEG_HIGH_ZERO), utility == '0)

endmodule

### dv/trapezoid_peak_utility_checker.sv
module trapezoid_peak_utility_checker
    import tpu_pkg::*;
#(
    parameter int FRACTION_BITS = TPU_FRACTION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [TPU_IDX_W-1:0]     point_index,
    input  logic                     done,
    input  logic [TPU_UTIL_W-1:0]    utility,
    input  logic [TPU_SEG_W-1:0]     segment,
    input  logic                     shape_valid,
    input  logic                     cfg_we,
    input  logic [TPU_CFG_IDX_W-1:0] cfg_index,
    input  logic [TPU_CFG_W-1:0]     cfg_data,
    output int                       mismatch_count,
    output int                       outstanding,
    output int                       scored_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TPU_UTIL_W-1:0] utility;
        logic [TPU_SEG_W-1:0]  segment;
        logic                  shape_valid;
    } score_t;

    logic [TPU_IDX_W-1:0]  summit     = '0;
    logic [TPU_IDX_W-1:0]  half_width = '0;
    logic [TPU_IDX_W-1:0]  ramp_width = '0;
    logic [TPU_DROP_W-1:0] drop_cfg   = '0;
    logic [TPU_HI_W-1:0]   points     = TPU_N_RESET;

    score_t expected_scores[$];
    score_t want;
    int     fails    = 0;
    int     inflight = 0;
    int     seen     = 0;

    assign mismatch_count = fails;
    assign outstanding    = inflight;
    assign scored_count   = seen;

    function automatic longint unsigned slope_frac(input longint unsigned num,
                                                   input longint unsigned den);
        if (den == 0)
            return 0;
        return (num << FRACTION_BITS) / den;
    endfunction

    function automatic score_t score_point(input logic [TPU_IDX_W-1:0] x_in);
        longint unsigned n, top_idx, s, w, b, drop, plat, x, full;
        longint unsigned lo_plat, hi_plat, lo_base, hi_base, value;
        score_t r;
        n = points;
        if (n < TPU_N_MIN)
            n = TPU_N_MIN;
        if (n > TPU_MAX_POINTS)
            n = TPU_MAX_POINTS;
        top_idx = n - 1;
        s = summit;
        w = half_width;
        b = ramp_width;
        full = TPU_FULL_UTIL;
        drop = drop_cfg;
        if (drop > full)
            drop = full;
        plat = full - drop;
        x = x_in;
        r = '0;
        // summit off the domain
        if (s > top_idx)
        begin
            r.segment = SEG_LOW_ZERO;
            return r;
        end
        lo_plat = (s > w) ? s - w : 0;
        hi_plat = (s + w < top_idx) ? s + w : top_idx;
        lo_base = (lo_plat > b) ? lo_plat - b : 0;
        hi_base = (hi_plat + b < top_idx) ? hi_plat + b : top_idx;
        value = 0;
        if (x > top_idx)
            r.segment = SEG_HIGH_ZERO;
        else if (x < lo_base)
            r.segment = SEG_LOW_ZERO;
        else if (x < lo_plat)
        begin
            r.segment = SEG_RAMP_UP;
            value = slope_frac(plat * (x + b - lo_plat), b);
        end
        else if (x < s)
        begin
            r.segment = SEG_RISE;
            value = slope_frac(plat * w + drop * (x + w - s), w);
        end
        else if (x == s)
        begin
            r.segment = SEG_SUMMIT;
            value = full << FRACTION_BITS;
        end
        else if (x <= hi_plat)
        begin
            r.segment = SEG_FALL;
            value = slope_frac(plat * w + drop * (s + w - x), w);
        end
        else if (x <= hi_base)
        begin
            r.segment = SEG_RAMP_DOWN;
            value = slope_frac(plat * (hi_plat + b - x), b);
        end
        else
            r.segment = SEG_HIGH_ZERO;
        r.utility = TPU_UTIL_W'(value);
        r.shape_valid = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summit = '0;
            half_width = '0;
            ramp_width = '0;
            drop_cfg = '0;
            points = TPU_N_RESET;
            expected_scores.delete();
            inflight = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SUMMIT_POINT:       summit = cfg_data[TPU_IDX_W-1:0];
                    REG_PLATEAU_HALF_WIDTH: half_width = cfg_data[TPU_IDX_W-1:0];
                    REG_BASE_RAMP_WIDTH:    ramp_width = cfg_data[TPU_IDX_W-1:0];
                    REG_SUMMIT_DROP:        drop_cfg = cfg_data[TPU_DROP_W-1:0];
                    REG_POINTS_IN_USE:      points = cfg_data[TPU_HI_W-1:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_scores.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("unexpected result: utility %0d segment %0d valid %0b",
                                 utility, segment, shape_valid);
                end
                else
                begin
                    want = expected_scores.pop_front();
                    inflight--;
                    seen++;
                    if (utility !== want.utility || segment !== want.segment
                        || shape_valid !== want.shape_valid)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                        begin
                            $display("mismatch on result %0d: expected utility %0d segment %0d valid %0b",
                                     seen, want.utility, want.segment, want.shape_valid);
                            $display("    got utility %0d segment %0d valid %0b",
                                     utility, segment, shape_valid);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                expected_scores.push_back(score_point(point_index));
                inflight++;
            end
        end
    end

endmodule

### dv/trapezoid_peak_utility_tb.sv
module trapezoid_peak_utility_tb;
    import tpu_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int CALM_TAIL   = 150;
    localparam int LATENCY     = 12 + TPU_FRACTION_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TPU_CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_POINTS_IN_USE + 1'b1;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [TPU_IDX_W-1:0]     point_index;
    logic                     done;
    logic [TPU_UTIL_W-1:0]    utility;
    logic [TPU_SEG_W-1:0]     segment;
    logic                     shape_valid;
    logic                     cfg_we;
    logic [TPU_CFG_IDX_W-1:0] cfg_index;
    logic [TPU_CFG_W-1:0]     cfg_data;

    int mismatch_count;
    int outstanding;
    int scored_count;
    int items_sent    = 0;
    int shapes_loaded = 0;
    int cycle_count   = 0;

    trapezoid_peak_utility dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point_index (point_index),
        .done        (done),
        .utility     (utility),
        .segment     (segment),
        .shape_valid (shape_valid),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    trapezoid_peak_utility_checker utility_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .point_index    (point_index),
        .done           (done),
        .utility        (utility),
        .segment        (segment),
        .shape_valid    (shape_valid),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .scored_count   (scored_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_point(input logic [TPU_IDX_W-1:0] x);
        @(negedge clk);
        start <= 1'b1;
        point_index <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_burst(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        point_index <= TPU_IDX_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [TPU_CFG_IDX_W-1:0] idx,
                             input logic [TPU_CFG_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // drain the pipe, then rewrite every register
    task automatic load_shape(input logic [TPU_CFG_W-1:0] s, input logic [TPU_CFG_W-1:0] w,
                              input logic [TPU_CFG_W-1:0] b, input logic [TPU_CFG_W-1:0] d,
                              input logic [TPU_CFG_W-1:0] n);
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        write_reg(REG_SUMMIT_POINT, s);
        write_reg(REG_PLATEAU_HALF_WIDTH, w);
        write_reg(REG_BASE_RAMP_WIDTH, b);
        write_reg(REG_SUMMIT_DROP, d);
        write_reg(REG_POINTS_IN_USE, n);
        // unmapped index, must be ignored
        write_reg(TPU_CFG_IDX_W'(REG_UNMAPPED_FIRST + $urandom_range(0, 2)),
                  TPU_CFG_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        shapes_loaded++;
    endtask

    function automatic logic [TPU_CFG_W-1:0] pick_width(input int span);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {1'($urandom), {TPU_IDX_W{1'b1}}};
            default: return {1'($urandom), TPU_IDX_W'($urandom_range(0, span))};
        endcase
    endfunction

    task automatic random_shape(output int win_lo, output int win_hi);
        logic [TPU_CFG_W-1:0] n_raw, s, w, b, d;
        int n_eff;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: n_raw = 0;
                    1: n_raw = 1;
                    2: n_raw = TPU_N_MIN;
                    3: n_raw = TPU_CFG_W'(TPU_MAX_POINTS);
                    default: n_raw = TPU_CFG_W'($urandom_range(TPU_MAX_POINTS + 1,
                                                               (1 << TPU_CFG_W) - 1));
                endcase
            end
            1, 2, 3: n_raw = TPU_CFG_W'($urandom_range(3, 64));
            default: n_raw = TPU_CFG_W'($urandom_range(TPU_N_MIN, TPU_MAX_POINTS));
        endcase
        n_eff = (n_raw < TPU_N_MIN) ? TPU_N_MIN
              : (n_raw > TPU_MAX_POINTS) ? TPU_MAX_POINTS : n_raw;
        if ($urandom_range(0, 9) == 0)
            s = TPU_CFG_W'($urandom_range(0, TPU_MAX_POINTS - 1));
        else
            s = TPU_CFG_W'($urandom_range(0, n_eff - 1));
        s[TPU_CFG_W-1] = 1'($urandom);
        w = pick_width(n_eff / 4 + 1);
        b = pick_width(n_eff / 4 + 1);
        case ($urandom_range(0, 5))
            0: d = 0;
            1: d = TPU_CFG_W'(TPU_FULL_UTIL);
            2: d = TPU_CFG_W'($urandom_range(TPU_FULL_UTIL + 1, (1 << TPU_DROP_W) - 1));
            default: d = TPU_CFG_W'($urandom_range(0, TPU_FULL_UTIL));
        endcase
        d[TPU_CFG_W-1:TPU_DROP_W] = (TPU_CFG_W-TPU_DROP_W)'($urandom);
        win_lo = int'(s[TPU_IDX_W-1:0]) - int'(w[TPU_IDX_W-1:0])
               - int'(b[TPU_IDX_W-1:0]) - 3;
        win_hi = int'(s[TPU_IDX_W-1:0]) + int'(w[TPU_IDX_W-1:0])
               + int'(b[TPU_IDX_W-1:0]) + 3;
        if (win_lo < 0)
            win_lo = 0;
        if (win_hi > TPU_MAX_POINTS - 1)
            win_hi = TPU_MAX_POINTS - 1;
        load_shape(s, w, b, d, n_raw);
    endtask

    initial
    begin
        int win_lo, win_hi, burst_pct;
        logic [TPU_IDX_W-1:0] x;
        rst_n = 1'b0;
        start = 1'b0;
        point_index = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset shape: zero widths, summit at 0
        send_point(0);
        send_point(1);
        send_point(TPU_MAX_POINTS - 1);

        // every piece of a regular trapezoid
        load_shape(500, 10, 20, 30, TPU_MAX_POINTS);
        send_point(469);
        send_point(470);
        send_point(480);
        send_point(490);
        send_point(495);
        send_point(500);
        send_point(505);
        send_point(510);
        send_point(520);
        send_point(530);
        send_point(531);

        // tiny domain, saturated drop, widest widths
        load_shape(1, {TPU_CFG_W{1'b1}}, {TPU_CFG_W{1'b1}}, {TPU_CFG_W{1'b1}}, 0);
        send_point(0);
        send_point(1);
        send_point(2);
        send_point(TPU_MAX_POINTS - 1);

        // summit at the top, oversized point count
        load_shape(TPU_MAX_POINTS - 1, 3, TPU_MAX_POINTS - 1, TPU_FULL_UTIL,
                   {TPU_CFG_W{1'b1}});
        send_point(TPU_MAX_POINTS - 1);
        send_point(TPU_MAX_POINTS - 4);
        send_point(TPU_MAX_POINTS - 5);
        send_point(0);

        // summit outside the domain
        load_shape(700, 5, 5, 10, 500);
        send_point(100);
        send_point(700);

        while (items_sent < ITEM_TARGET)
        begin
            random_shape(win_lo, win_hi);
            burst_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            repeat ($urandom_range(20, 60))
            begin
                if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(1, 100) <= burst_pct)
                    idle_burst($urandom_range(1, 14));
                if ($urandom_range(0, 4) == 0)
                    x = TPU_IDX_W'($urandom_range(0, TPU_MAX_POINTS - 1));
                else
                    x = TPU_IDX_W'($urandom_range(win_lo, win_hi));
                send_point(x);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("%0d points evaluated over %0d shapes, %0d results compared",
                 items_sent, shapes_loaded, scored_count);
        $display("shapes spanned zero and full widths, clamped point counts, %s",
                 "saturated drops and summits off the domain");
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/tpu_pkg.sv
hdl/tpu_div_pipe.sv
hdl/trapezoid_peak_utility.sv
dv/trapezoid_peak_utility_checker.sv
dv/trapezoid_peak_utility_tb.sv
